// ===== design/pbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types and constants of the palette bitmap decoder.
// ----------------------------------------------------------------------------
package pbd_pkg;

	// Image dimension limit and field widths
	localparam int unsigned MAX_DIM_DEF = 4096;
	localparam int unsigned DIM_W       = 13;
	localparam int unsigned PROD_W      = 25;
	localparam int unsigned OFS_W       = 12;

	// File layout
	localparam logic [31:0]      HDR_BYTES = 32'd32;
	localparam logic [31:0]      PAL_END   = 32'd1056;
	localparam logic [OFS_W-1:0] PAL_BASE  = 12'd1056;

	// Decoder phase
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_PALETTE,
		PH_PIXELS,
		PH_DRAIN
	} phase_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK,
		ST_SHORT,
		ST_DIMS,
		ST_FLAGS,
		ST_TRUNC
	} status_t;

	// Palette memory access from control
	typedef struct packed {
		logic        wr_en;
		logic [7:0]  wr_addr;
		logic [31:0] wr_data;
		logic        rd_en;
		logic [7:0]  rd_addr;
	} pal_ctl_t;

	// Result description from control
	typedef struct packed {
		logic             emit;
		status_t          status;
		logic             last;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} res_t;

endpackage

// ===== design/pbd_byte_if.sv =====
// ----------------------------------------------------------------------------
// pbd_byte_if
// File byte stream: one file byte per transaction with the file length.
// ----------------------------------------------------------------------------
interface pbd_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  file_byte;
	logic [31:0] file_length;

	modport source(output valid, output file_byte, output file_length, input ready);
	modport sink(input valid, input file_byte, input file_length, output ready);
endinterface

// ===== design/pbd_pix_if.sv =====
// ----------------------------------------------------------------------------
// pbd_pix_if
// Pixel stream: one RGBA pixel or one error result per transaction.
// ----------------------------------------------------------------------------
interface pbd_pix_if;
	logic                     valid;
	logic                     ready;
	logic [31:0]              rgba;
	logic [pbd_pkg::DIM_W-1:0] image_width;
	logic [pbd_pkg::DIM_W-1:0] image_height;
	logic [2:0]               status;
	logic                     last;

	modport source(output valid, output rgba, output image_width, output image_height,
		output status, output last, input ready);
	modport sink(input valid, input rgba, input image_width, input image_height,
		input status, input last, output ready);
endinterface

// ===== design/pbd_pal_ram.sv =====
// ----------------------------------------------------------------------------
// pbd_pal_ram
// 256 x 32 palette memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pbd_pal_ram (
	input  logic              clk,
	input  pbd_pkg::pal_ctl_t ctl,
	output logic [31:0]       rdata
);
	import pbd_pkg::*;

	logic [31:0] mem [256];

	// Write a completed palette entry
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= ctl.wr_data;
		end
	end

	// Read the entry for a pixel index; hold while not enabled
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata <= mem[ctl.rd_addr];
		end
	end
endmodule

// ===== design/pbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbd_ctrl
// File parser: byte position, header capture and checks, palette write
// addressing, pixel counting and the phase state machine.
// ----------------------------------------------------------------------------
module pbd_ctrl #(
	parameter int unsigned MAX_DIM = pbd_pkg::MAX_DIM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [7:0]        byte_s1,
	input  logic [31:0]       length_s1,
	output pbd_pkg::pal_ctl_t pal,
	output pbd_pkg::res_t     res
);
	import pbd_pkg::*;

	phase_t              phase_q, phase_n, work;
	logic [31:0]         pos_q, len_q, pos_c, len_c;
	logic [32:0]         pos_n;
	logic [31:0]         width_q, height_q, flags_q;
	logic [PROD_W-1:0]   prod_q, remain_q;
	logic [OFS_W-1:0]    need_q, pix_start_q;
	logic [23:0]         hold_q;
	logic                at_check, dims_bad, flags_bad, trunc, hdr_err, fin;
	logic [PROD_W:0]     span;
	status_t             chk_status;

	// Effective view of the current byte: a new file starts from idle
	always_comb begin
		len_c = (phase_q == PH_IDLE) ? length_s1 : len_q;
		pos_c = (phase_q == PH_IDLE) ? '0 : pos_q;
		work  = phase_q;
		if (phase_q == PH_IDLE) begin
			work = (length_s1 < HDR_BYTES) ? PH_DRAIN : PH_HEADER;
		end
		pos_n = {1'b0, pos_c} + 33'd1;
	end

	// Header checks on the last header byte
	always_comb begin
		at_check  = (work == PH_HEADER) && (pos_c == HDR_BYTES - 32'd1);
		dims_bad  = (width_q == '0) || (height_q == '0) ||
			(width_q > 32'(MAX_DIM)) || (height_q > 32'(MAX_DIM));
		flags_bad = !((flags_q == 32'd1) || ((flags_q >= 32'd3) && (flags_q <= 32'd257)));
		span      = (PROD_W + 1)'(need_q) + (PROD_W + 1)'(prod_q);
		trunc     = 32'(span) > len_q;
		hdr_err   = dims_bad || flags_bad || trunc;
		if (dims_bad) begin
			chk_status = ST_DIMS;
		end else if (flags_bad) begin
			chk_status = ST_FLAGS;
		end else begin
			chk_status = ST_TRUNC;
		end
		fin = (remain_q == PROD_W'(1));
	end

	// Next phase
	always_comb begin
		phase_n = work;
		case (work)
			PH_HEADER: begin
				if (at_check) begin
					phase_n = hdr_err ? PH_DRAIN : PH_PALETTE;
				end
			end
			PH_PALETTE: begin
				if (pos_n >= 33'(pix_start_q)) begin
					phase_n = PH_PIXELS;
				end
			end
			PH_PIXELS: begin
				if (fin) begin
					phase_n = PH_DRAIN;
				end
			end
			default: begin
				phase_n = work;
			end
		endcase
		if (pos_n >= {1'b0, len_c}) begin
			phase_n = PH_IDLE;
		end
	end

	// Result and palette access for the current byte
	always_comb begin
		res         = '0;
		res.status  = ST_OK;
		pal         = '0;
		pal.wr_addr = 8'(pos_c[9:2] - 8'd8);
		pal.wr_data = {byte_s1, hold_q};
		pal.rd_addr = byte_s1;
		if ((phase_q == PH_IDLE) && (length_s1 < HDR_BYTES)) begin
			res.emit   = 1'b1;
			res.status = ST_SHORT;
			res.last   = 1'b1;
		end
		case (work)
			PH_HEADER: begin
				if (at_check && hdr_err) begin
					res.emit   = 1'b1;
					res.status = chk_status;
					res.last   = 1'b1;
				end
			end
			PH_PALETTE: begin
				pal.wr_en = adv && (pos_c < PAL_END) && (pos_c[1:0] == 2'd3);
			end
			PH_PIXELS: begin
				pal.rd_en = adv;
				res.emit  = 1'b1;
				res.last  = fin;
				if (fin) begin
					res.width  = width_q[DIM_W-1:0];
					res.height = height_q[DIM_W-1:0];
				end
			end
			default: begin
				pal.rd_en = 1'b0;
			end
		endcase
	end

	// Advance phase and position per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			len_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_n;
			pos_q   <= pos_n[31:0];
			len_q   <= len_c;
		end
	end

	// Capture header words, palette byte lanes and pixel counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= '0;
			height_q    <= '0;
			flags_q     <= '0;
			hold_q      <= '0;
			pix_start_q <= '0;
			remain_q    <= '0;
		end else if (adv) begin
			if (work == PH_HEADER) begin
				case (pos_c[4:2])
					3'd1: width_q[8*pos_c[1:0] +: 8]  <= byte_s1;
					3'd2: height_q[8*pos_c[1:0] +: 8] <= byte_s1;
					3'd4: flags_q[8*pos_c[1:0] +: 8]  <= byte_s1;
					default: begin
						hold_q <= hold_q;
					end
				endcase
			end
			if ((work == PH_PALETTE) && (pos_c[1:0] != 2'd3)) begin
				hold_q[8*pos_c[1:0] +: 8] <= byte_s1;
			end
			if (at_check) begin
				pix_start_q <= need_q;
				remain_q    <= prod_q;
			end
			if (work == PH_PIXELS) begin
				remain_q <= remain_q - PROD_W'(1);
			end
		end
	end

	// Precompute pixel count and palette end from the settled header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
			need_q <= '0;
		end else begin
			prod_q <= PROD_W'(width_q[DIM_W-1:0]) * PROD_W'(height_q[DIM_W-1:0]);
			need_q <= PAL_BASE + OFS_W'({flags_q[8:0] - 9'd1, 2'b00});
		end
	end
endmodule

// ===== design/palette_bitmap_decoder.sv =====
// ----------------------------------------------------------------------------
// palette_bitmap_decoder
// Streaming decoder for 8-bit palette bitmaps with RGBA pixel output.
// ----------------------------------------------------------------------------
// The decoder takes one file byte per clock and gives at most one result per
// byte: header and palette bytes are absorbed, each index byte yields one RGBA
// pixel, and a failed check yields a single error result with last set, after
// which the rest of the file is dropped. A byte passes an input register and
// then a result register, which presents its result; these two registers set
// the latency, and the palette read is registered into the result stage
// alongside them. Throughput is one byte per cycle as long as results are taken.
// No clearing pass follows reset; the palette is always fully loaded before
// any pixel of a file reads it.
module palette_bitmap_decoder #(
	parameter int unsigned MAX_DIM = pbd_pkg::MAX_DIM_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	pbd_byte_if.sink  file_in,
	pbd_pix_if.source pix_out
);
	import pbd_pkg::*;

	logic        valid_s1, valid_s2, adv;
	logic [7:0]  byte_s1;
	logic [31:0] length_s1, rdata;
	res_t        res, res_s2;
	pal_ctl_t    pal;

	// Move a byte on when the result stage is free or being drained
	assign adv           = valid_s1 && (!valid_s2 || pix_out.ready);
	assign file_in.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (file_in.ready) begin
			valid_s1 <= file_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (file_in.valid && file_in.ready) begin
			byte_s1   <= file_in.file_byte;
			length_s1 <= file_in.file_length;
		end
	end

	pbd_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.byte_s1   (byte_s1),
		.length_s1 (length_s1),
		.pal       (pal),
		.res       (res)
	);

	pbd_pal_ram u_pal_ram (
		.clk   (clk),
		.ctl   (pal),
		.rdata (rdata)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= res.emit;
		end else if (pix_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	// Drive the result transaction
	assign pix_out.valid        = valid_s2;
	assign pix_out.rgba         = (res_s2.status == ST_OK) ? rdata : '0;
	assign pix_out.image_width  = res_s2.width;
	assign pix_out.image_height = res_s2.height;
	assign pix_out.status       = res_s2.status;
	assign pix_out.last         = res_s2.last;
endmodule
